// ===== rtl/pdb_pkg.sv =====
// Package: shared types, register map and limits for the PID controller.
`timescale 1ns / 1ps

package pdb_pkg;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_TARGET   = 3'd0;
  localparam logic [2:0] REG_GAIN_P   = 3'd1;
  localparam logic [2:0] REG_GAIN_I   = 3'd2;
  localparam logic [2:0] REG_GAIN_D   = 3'd3;
  localparam logic [2:0] REG_DEADBAND = 3'd4;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Integral clamp on the 25-bit pre-clamp sum
  localparam logic signed [24:0] INTEGRAL_LIMIT = 25'sd6000000;
  // Drive clamp on the 35-bit shifted accumulator
  localparam logic signed [34:0] DRIVE_LIMIT    = 35'sd10000;

  typedef struct packed {
    logic signed [15:0] target_value;
    logic signed [23:0] gain_prop;
    logic signed [23:0] gain_integ;
    logic signed [23:0] gain_deriv;
    logic        [14:0] deadband_limit;
  } cfg_t;

endpackage

// ===== rtl/pdb_regs.sv =====
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module pdb_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pdb_pkg::ADDR_W-1:0]  paddr,
  input  logic [pdb_pkg::DATA_W-1:0]  pwdata,
  output logic [pdb_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output pdb_pkg::cfg_t               cfg
);

  pdb_pkg::cfg_t cfg_r;
  pdb_pkg::cfg_t cfg_nxt;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        pdb_pkg::REG_TARGET:   cfg_nxt.target_value   = pwdata[15:0];
        pdb_pkg::REG_GAIN_P:   cfg_nxt.gain_prop      = pwdata[23:0];
        pdb_pkg::REG_GAIN_I:   cfg_nxt.gain_integ     = pwdata[23:0];
        pdb_pkg::REG_GAIN_D:   cfg_nxt.gain_deriv     = pwdata[23:0];
        pdb_pkg::REG_DEADBAND: cfg_nxt.deadband_limit = pwdata[14:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      pdb_pkg::REG_TARGET:   prdata = {16'd0, cfg_r.target_value};
      pdb_pkg::REG_GAIN_P:   prdata = {8'd0, cfg_r.gain_prop};
      pdb_pkg::REG_GAIN_I:   prdata = {8'd0, cfg_r.gain_integ};
      pdb_pkg::REG_GAIN_D:   prdata = {8'd0, cfg_r.gain_deriv};
      pdb_pkg::REG_DEADBAND: prdata = {17'd0, cfg_r.deadband_limit};
      default:               prdata = '0;
    endcase
  end

endmodule

// ===== rtl/pdb_calc.sv =====
// PID datapath: error, deadband, integral/derivative state and drive clamp.
`timescale 1ns / 1ps

module pdb_calc (
  input  logic               clk,
  input  logic               rst_n,
  input  pdb_pkg::cfg_t      cfg,
  input  logic signed [15:0] meas,
  input  logic               upd,       // item moves to output: commit state
  output logic signed [14:0] drive,
  output logic               in_db
);

  logic signed [23:0] integral_r;
  logic signed [23:0] integral_nxt;
  logic signed [16:0] error_prev_r;
  logic signed [16:0] error_prev_nxt;

  logic signed [16:0] err;
  logic signed [17:0] err_x;
  logic signed [17:0] db_x;
  logic signed [24:0] integ_sum;
  logic signed [23:0] integ_clamped;
  logic signed [17:0] err_diff;
  logic signed [40:0] p_prop;
  logic signed [47:0] p_integ;
  logic signed [41:0] p_deriv;
  logic signed [50:0] acc;
  logic signed [34:0] acc_sh;
  logic signed [34:0] drive_cl;

  assign err   = 17'(cfg.target_value) - 17'(meas);
  assign err_x = 18'(err);
  assign db_x  = $signed({3'b000, cfg.deadband_limit});
  assign in_db = (err_x <= db_x) && (err_x >= -db_x);

  assign integ_sum = 25'(integral_r) + 25'(err);

  always_comb begin
    priority if (integ_sum > pdb_pkg::INTEGRAL_LIMIT) begin
      integ_clamped = pdb_pkg::INTEGRAL_LIMIT[23:0];
    end else if (integ_sum < -pdb_pkg::INTEGRAL_LIMIT) begin
      integ_clamped = 24'(-pdb_pkg::INTEGRAL_LIMIT);
    end else begin
      integ_clamped = integ_sum[23:0];
    end
  end

  assign err_diff = 18'(err) - 18'(error_prev_r);

  assign p_prop  = 41'(cfg.gain_prop) * 41'(err);
  assign p_integ = 48'(cfg.gain_integ) * 48'(integ_clamped);
  assign p_deriv = 42'(cfg.gain_deriv) * 42'(err_diff);

  assign acc    = 51'(p_prop) + 51'(p_integ) + 51'(p_deriv);
  assign acc_sh = acc[50:16];  // arithmetic shift, floor

  always_comb begin
    priority if (acc_sh > pdb_pkg::DRIVE_LIMIT) begin
      drive_cl = pdb_pkg::DRIVE_LIMIT;
    end else if (acc_sh < -pdb_pkg::DRIVE_LIMIT) begin
      drive_cl = -pdb_pkg::DRIVE_LIMIT;
    end else begin
      drive_cl = acc_sh;
    end
  end

  assign drive = in_db ? 15'sd0 : drive_cl[14:0];

  always_comb begin
    integral_nxt   = integral_r;
    error_prev_nxt = error_prev_r;
    if (upd) begin
      if (in_db) begin
        integral_nxt = '0;
      end else begin
        integral_nxt   = integ_clamped;
        error_prev_nxt = err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r   <= '0;
      error_prev_r <= '0;
    end else begin
      integral_r   <= integral_nxt;
      error_prev_r <= error_prev_nxt;
    end
  end

endmodule

// ===== rtl/pid_deadband_saturating.sv =====
// Top level: positional PID controller with deadband and output saturation.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid/in_ready    in_measured_value[15:0]
//  out_     output     out_valid/out_ready  out_drive_value[14:0], out_in_deadband
//  cfg      input      psel/penable/pready  paddr[4:0], pwdata/prdata[31:0]
//
// One item per cycle sustained while out_ready holds. An accepted item sits in
// the input register; the whole PID step is worked out from it and lands in the
// result register. Integral and previous-error state commit as the item moves
// there, ready for the next item (in the deadband the integral clears and the
// previous error is kept). A stalled result holds itself and a full input
// stage; rst_n clears state, gains and setpoint synchronously.
`timescale 1ns / 1ps

module pid_deadband_saturating (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [15:0]          in_measured_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [14:0]          out_drive_value,
  output logic                        out_in_deadband,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pdb_pkg::ADDR_W-1:0]  paddr,
  input  logic [pdb_pkg::DATA_W-1:0]  pwdata,
  output logic [pdb_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  pdb_pkg::cfg_t      cfg;
  logic               stg_valid_r;
  logic               stg_valid_nxt;
  logic signed [15:0] meas_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic signed [14:0] drive_r;
  logic               db_r;
  logic               adv;
  logic               upd;
  logic signed [14:0] drive_c;
  logic               db_c;

  pdb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pdb_calc u_calc (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .meas  (meas_r),
    .upd   (upd),
    .drive (drive_c),
    .in_db (db_c)
  );

  // result register free or being drained this cycle
  assign adv      = !out_valid_r || out_ready;
  assign upd      = adv && stg_valid_r;
  assign in_ready = !stg_valid_r || adv;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_ready) begin
      stg_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = stg_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      meas_r <= in_measured_value;
    end
    if (upd) begin
      drive_r <= drive_c;
      db_r    <= db_c;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_value = drive_r;
  assign out_in_deadband = db_r;

endmodule
